### rtl/qrv_pkg.sv
// Shared constants for the quaternion vector rotation pipeline.
package qrv_pkg;

  // Width of the intermediate product q * (v, 0), saturated to signed 64 bits
  localparam int unsigned P_W = 64;

  // Register stages inside one split multiplier
  localparam int unsigned MUL_LAT = 2;

endpackage

### rtl/qrv_if.sv
// Valid/ready channel interfaces for the rotation input and result transactions.
interface qrv_in_if #(
  parameter int DW = 32
) ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] quat_x;
  logic [DW-1:0] quat_y;
  logic [DW-1:0] quat_z;
  logic [DW-1:0] quat_w;
  logic [DW-1:0] vec_x;
  logic [DW-1:0] vec_y;
  logic [DW-1:0] vec_z;
  logic          already_unit;

  modport source (
    output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, already_unit,
    input  ready
  );
  modport sink (
    input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, already_unit,
    output ready
  );
endinterface

interface qrv_out_if #(
  parameter int DW = 32
) ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] rot_x;
  logic [DW-1:0] rot_y;
  logic [DW-1:0] rot_z;

  modport source (
    output valid, rot_x, rot_y, rot_z,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z,
    output ready
  );
endinterface

### rtl/quaternion_rotate_vector_top.sv
// Throughput: one transaction per cycle; a stalled output holds the whole pipeline.
// Depth is set by the square root (one root bit per stage, DATA_WIDTH + 1 stages)
// and the restoring divider (one quotient bit per stage, FRAC_BITS + 1 stages).
// Reset clears only the per-stage valid bits; the datapath registers are not reset.
module quaternion_rotate_vector_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qrv_in_if.sink    in_if,
  qrv_out_if.source out_if
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int ML  = qrv_pkg::MUL_LAT;
  localparam int PW  = qrv_pkg::P_W;
  localparam int MW  = DW + 1;                       // magnitude width
  localparam int SW  = 2 * MW;                       // sum of squares width
  localparam int QW  = (DW > FB + 2) ? DW : FB + 2;  // working quaternion width
  localparam int H1P = QW + DW;
  localparam int H1S = H1P + 2;
  localparam int H2P = PW + QW;
  localparam int H2S = H2P + 2;
  localparam int E1  = (H1S > PW) ? H1S : PW + 1;
  localparam int T0  = ML + 1;                       // sum of squares ready
  localparam int DT  = T0 + MW - 1;                  // input tap at the divider
  localparam int ND  = T0 + MW + FB + 1;             // input delay line depth
  localparam int T1  = ND + 1;                       // working quaternion ready
  localparam int QD  = ML + 2;
  localparam int LAT = T1 + 2 * ML + 4;
  localparam int XW  = 1 + 7 * DW;

  // first product terms: q index, v index, negate
  localparam int H1_A [12] = '{3, 1, 2, 3, 0, 2, 3, 0, 1, 0, 1, 2};
  localparam int H1_B [12] = '{0, 2, 1, 1, 2, 0, 2, 1, 0, 0, 1, 2};
  localparam bit H1_N [12] = '{0, 0, 1, 0, 1, 0, 0, 0, 1, 1, 1, 1};
  // second product terms against conj(q): p index, q index, negate
  localparam int H2_A [12] = '{3, 0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2};
  localparam int H2_B [12] = '{0, 3, 2, 1, 1, 2, 3, 0, 2, 1, 0, 3};
  localparam bit H2_N [12] = '{1, 0, 1, 0, 1, 0, 0, 1, 1, 1, 0, 0};

  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic signed [DW-1:0] qin [4];
  logic [XW-1:0]        xin;
  logic [XW-1:0]        xd_r [ND];

  // pipeline advance and valid bits
  assign en           = !vld_r[LAT-1] || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_if.valid};
    end
  end

  assign qin[0] = in_if.quat_x;
  assign qin[1] = in_if.quat_y;
  assign qin[2] = in_if.quat_z;
  assign qin[3] = in_if.quat_w;
  assign xin    = {in_if.already_unit, in_if.vec_z, in_if.vec_y, in_if.vec_x,
                   in_if.quat_w, in_if.quat_z, in_if.quat_y, in_if.quat_x};

  // input delay line up to the select stage
  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[0] <= xin;
      for (int k = 1; k < ND; k++) begin
        xd_r[k] <= xd_r[k-1];
      end
    end
  end

  // squares and their sum
  logic signed [2*DW-1:0] sq [4];
  logic [SW-1:0]          s_r;

  for (genvar g = 0; g < 4; g++) begin : g_sq
    qrv_mul #(.AW(DW), .BW(DW)) u_sq (
      .clk (clk),
      .en  (en),
      .a   (qin[g]),
      .b   (qin[g]),
      .p   (sq[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= SW'($unsigned(sq[0])) + SW'($unsigned(sq[1])) + SW'($unsigned(sq[2]))
             + SW'($unsigned(sq[3]));
    end
  end

  // square root, one root bit per stage, residual kept as S - root^2
  logic [MW-1:0] rt_r [MW];
  logic [SW-1:0] er_r [MW-1];

  for (genvar j = 0; j < MW; j++) begin : g_sqrt
    localparam int B = MW - 1 - j;
    logic [MW-1:0] rt_in;
    logic [SW-1:0] er_in;
    logic [SW-1:0] t;
    logic          ge;

    if (j == 0) begin : g_first
      assign rt_in = '0;
      assign er_in = s_r;
    end else begin : g_next
      assign rt_in = rt_r[j-1];
      assign er_in = er_r[j-1];
    end

    assign t  = (SW'(rt_in) << (B + 1)) | (SW'(1) << (2 * B));
    assign ge = er_in >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[j] <= ge ? (rt_in | (MW'(1) << B)) : rt_in;
      end
    end

    if (j < MW - 1) begin : g_res
      always_ff @(posedge clk) begin
        if (en) begin
          er_r[j] <= ge ? er_in - t : er_in;
        end
      end
    end
  end

  // restoring divide |q_i| * 2^FB / M, one quotient bit per stage
  logic [MW-1:0] dm_r [FB+1];
  logic [FB:0]   dq_r [4][FB+1];
  logic [MW-1:0] dr_r [4][FB];

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0] <= rt_r[MW-1];
      for (int k = 1; k <= FB; k++) begin
        dm_r[k] <= dm_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    logic [DW-1:0] tq;
    logic [DW-1:0] amag;
    logic [MW-1:0] a_ext;
    logic          ge0;

    assign tq    = xd_r[DT][i*DW +: DW];
    assign amag  = tq[DW-1] ? DW'(~tq + 1'b1) : tq;
    assign a_ext = MW'(amag);
    assign ge0   = a_ext >= rt_r[MW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[i][0] <= {{FB{1'b0}}, ge0};
        dr_r[i][0] <= ge0 ? a_ext - rt_r[MW-1] : a_ext;
      end
    end

    for (genvar k = 1; k <= FB; k++) begin : g_stg
      logic [MW:0] r2;
      logic        ge;

      assign r2  = {dr_r[i][k-1], 1'b0};
      assign ge  = r2 >= {1'b0, dm_r[k-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          dq_r[i][k] <= {dq_r[i][k-1][FB-1:0], ge};
        end
      end

      if (k < FB) begin : g_rem
        // remainder stays below the divisor, so the low bits suffice
        logic [MW-1:0] dif;

        assign dif = r2[MW-1:0] - dm_r[k-1];

        always_ff @(posedge clk) begin
          if (en) begin
            dr_r[i][k] <= ge ? dif : r2[MW-1:0];
          end
        end
      end
    end
  end

  // select raw or normalized quaternion, or zero when the magnitude is zero
  logic signed [QW-1:0] qn_r [4];
  logic signed [DW-1:0] v1_r [3];
  logic                 unit_s;

  assign unit_s = xd_r[ND-1][7*DW];

  for (genvar i = 0; i < 4; i++) begin : g_sel
    logic signed [DW-1:0] qraw;
    logic signed [QW-1:0] quo_s;
    logic signed [QW-1:0] qsel;

    assign qraw  = xd_r[ND-1][i*DW +: DW];
    assign quo_s = QW'($signed({1'b0, dq_r[i][FB]}));

    always_comb begin
      priority if (unit_s) begin
        qsel = QW'(qraw);
      end else if (dm_r[FB] == '0) begin
        qsel = '0;
      end else begin
        qsel = qraw[DW-1] ? -quo_s : quo_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qn_r[i] <= qsel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= xd_r[ND-1][(4+i)*DW +: DW];
      end
    end
  end

  // quaternion held for the second product
  logic signed [QW-1:0] qnd_r [QD][4];

  always_ff @(posedge clk) begin
    if (en) begin
      qnd_r[0] <= qn_r;
      for (int k = 1; k < QD; k++) begin
        qnd_r[k] <= qnd_r[k-1];
      end
    end
  end

  // first product q * (v, 0)
  logic signed [H1P-1:0] h1p [12];
  logic signed [H1S-1:0] h1t [12];
  logic signed [H1S-1:0] h1s_r [4];
  logic signed [PW-1:0]  p_r [4];

  for (genvar g = 0; g < 12; g++) begin : g_h1
    qrv_mul #(.AW(QW), .BW(DW)) u_m1 (
      .clk (clk),
      .en  (en),
      .a   (qn_r[H1_A[g]]),
      .b   (v1_r[H1_B[g]]),
      .p   (h1p[g])
    );
    assign h1t[g] = H1_N[g] ? -(H1S'(h1p[g])) : H1S'(h1p[g]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        h1s_r[c] <= h1t[3*c] + h1t[3*c+1] + h1t[3*c+2];
      end
    end
  end

  // shift down (floor) and saturate to 64 bits
  for (genvar c = 0; c < 4; c++) begin : g_sat1
    logic signed [H1S-1:0] sh1;
    logic signed [E1-1:0]  ex1;
    logic                  ov1;

    assign sh1 = h1s_r[c] >>> FB;
    assign ex1 = E1'(sh1);
    assign ov1 = !((&ex1[E1-1:PW-1]) || !(|ex1[E1-1:PW-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        if (ov1) begin
          p_r[c] <= ex1[E1-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
          p_r[c] <= ex1[PW-1:0];
        end
      end
    end
  end

  // second product p * conj(q), vector part only
  logic signed [H2P-1:0] h2p [12];
  logic signed [H2S-1:0] h2t [12];
  logic signed [H2S-1:0] h2s_r [3];
  logic signed [DW-1:0]  rot_r [3];

  for (genvar g = 0; g < 12; g++) begin : g_h2
    qrv_mul #(.AW(PW), .BW(QW)) u_m2 (
      .clk (clk),
      .en  (en),
      .a   (p_r[H2_A[g]]),
      .b   (qnd_r[QD-1][H2_B[g]]),
      .p   (h2p[g])
    );
    assign h2t[g] = H2_N[g] ? -(H2S'(h2p[g])) : H2S'(h2p[g]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        h2s_r[c] <= h2t[4*c] + h2t[4*c+1] + h2t[4*c+2] + h2t[4*c+3];
      end
    end
  end

  // shift down (floor) and saturate to the output width
  for (genvar c = 0; c < 3; c++) begin : g_sat2
    logic signed [H2S-1:0] sh2;
    logic                  ov2;

    assign sh2 = h2s_r[c] >>> FB;
    assign ov2 = !((&sh2[H2S-1:DW-1]) || !(|sh2[H2S-1:DW-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        if (ov2) begin
          rot_r[c] <= sh2[H2S-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
          rot_r[c] <= sh2[DW-1:0];
        end
      end
    end
  end

  assign out_if.rot_x = rot_r[0];
  assign out_if.rot_y = rot_r[1];
  assign out_if.rot_z = rot_r[2];

endmodule

### rtl/qrv_mul.sv
// Two-stage signed multiplier split into four half-width partial products.
module qrv_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AH-1:0]      ah;
  logic signed [BH-1:0]      bh;
  logic signed [AL:0]        al_s;
  logic signed [BL:0]        bl_s;
  logic signed [AH+BH-1:0]   hh_r;
  logic signed [AH+BL:0]     hl_r;
  logic signed [AL+BH:0]     lh_r;
  logic [AL+BL-1:0]          ll_r;
  logic signed [PW-1:0]      p_r;

  // high halves signed, low halves as non-negative values
  assign ah   = a[AW-1:AL];
  assign bh   = b[BW-1:BL];
  assign al_s = {1'b0, a[AL-1:0]};
  assign bl_s = {1'b0, b[BL-1:0]};

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= ah * bl_s;
      lh_r <= al_s * bh;
      ll_r <= a[AL-1:0] * b[BL-1:0];
    end
  end

  // stage 2: align and add
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (PW'(hh_r) <<< (AL + BL)) + (PW'(hl_r) <<< AL) + (PW'(lh_r) <<< BL)
             + PW'(ll_r);
    end
  end

  assign p = p_r;

endmodule

### rtl/qrv_chk.sv
// Port-level checker for the rotation pipeline, bound to the top level.
module qrv_chk #(
  parameter int LAT = 62,
  parameter int DW  = 32
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [DW-1:0] rot_x,
  input logic [DW-1:0] rot_y,
  input logic [DW-1:0] rot_z
);

  localparam int CW = $clog2(LAT + 2);

  logic [CW-1:0] cnt_r;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CW'(in_acc) - CW'(out_acc);
    end
  end

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y)
                                && $stable(rot_z))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != '0)
    else $error("result without a pending transaction");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LAT))
    else $error("more transactions in flight than pipeline stages");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output drains");

endmodule

bind quaternion_rotate_vector_top qrv_chk #(.LAT(LAT), .DW(DW)) u_qrv_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .rot_x     (out_if.rot_x),
  .rot_y     (out_if.rot_y),
  .rot_z     (out_if.rot_z)
);

### tb/sv/testbench.sv
// Testbench for the quaternion vector rotation pipeline: queue-fed driver, checking monitor.
`timescale 1ns / 100ps

module testbench;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int HOLD_AT = 150;   // results taken before the long receiver hold-off
  localparam int HOLD_LEN = 300;  // hold-off length, well past the pipeline depth
  localparam int DRAIN = 80;      // pipeline is 62 deep at these widths

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [63:0] s64_t;
  typedef logic signed [129:0] wide_t;

  typedef struct {
    word_t quat[4];  // x, y, z, w
    word_t vec[3];
    logic  unit;
  } rot_req_t;

  typedef struct {
    word_t v[3];
  } rot_vec_t;

  logic clk;
  logic rst_n;

  qrv_in_if  #(.DW(DW)) in_ch ();
  qrv_out_if #(.DW(DW)) out_ch ();

  quaternion_rotate_vector_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  rot_req_t pending_reqs[$];
  rot_vec_t expected_rots[$];
  int       errors;
  int       results_seen;
  bit       send_burst;  // no sender gaps while set
  bit       take_burst;  // no receiver stalls while set

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #400us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Saturate an exact value to a signed width of w bits
  function automatic s64_t clamp(input wide_t x, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return s64_t'(hi);
    if (x < lo) return s64_t'(lo);
    return s64_t'(x);
  endfunction

  // Hamilton product a*b, order x, y, z, w, each part floored and clamped to w bits
  function automatic void hamilton(input s64_t a[4], input s64_t b[4], input int w,
                                   output s64_t r[4]);
    wide_t aw[4];
    wide_t bw[4];
    wide_t t[4];
    for (int i = 0; i < 4; i++) begin
      aw[i] = a[i];
      bw[i] = b[i];
    end
    t[0] = aw[3]*bw[0] + aw[0]*bw[3] + aw[1]*bw[2] - aw[2]*bw[1];
    t[1] = aw[3]*bw[1] - aw[0]*bw[2] + aw[1]*bw[3] + aw[2]*bw[0];
    t[2] = aw[3]*bw[2] + aw[0]*bw[1] - aw[1]*bw[0] + aw[2]*bw[3];
    t[3] = aw[3]*bw[3] - aw[0]*bw[0] - aw[1]*bw[1] - aw[2]*bw[2];
    for (int i = 0; i < 4; i++) r[i] = clamp(t[i] >>> FB, w);
  endfunction

  // Expected rotated vector for one request
  function automatic rot_vec_t rotate(input rot_req_t req);
    s64_t q[4];
    s64_t v[4];
    s64_t cq[4];
    s64_t p[4];
    s64_t r[4];
    logic [127:0] sum_sq;
    logic [127:0] mag;
    logic [127:0] trial;
    logic [127:0] absc;
    rot_vec_t res;
    for (int i = 0; i < 4; i++) q[i] = req.quat[i];
    for (int i = 0; i < 3; i++) v[i] = req.vec[i];
    v[3] = '0;
    if (!req.unit) begin
      sum_sq = '0;
      for (int i = 0; i < 4; i++) begin
        absc = q[i] < 0 ? 128'(-q[i]) : 128'(q[i]);
        sum_sq += absc * absc;
      end
      // floor square root, one bit at a time
      mag = '0;
      for (int b = 63; b >= 0; b--) begin
        trial = mag | (128'(1) << b);
        if (trial * trial <= sum_sq) mag = trial;
      end
      for (int i = 0; i < 4; i++) begin
        absc = q[i] < 0 ? 128'(-q[i]) : 128'(q[i]);
        if (mag == 0) q[i] = '0;
        else begin
          absc = (absc << FB) / mag;
          q[i] = q[i] < 0 ? -s64_t'(absc) : s64_t'(absc);
        end
      end
    end
    for (int i = 0; i < 3; i++) cq[i] = -q[i];
    cq[3] = q[3];
    hamilton(q, v, 64, p);
    hamilton(p, cq, DW, r);
    for (int i = 0; i < 3; i++) res.v[i] = word_t'(r[i]);
    return res;
  endfunction

  function automatic rot_req_t make_req(input int qx, input int qy, input int qz,
                                        input int qw, input int vx, input int vy,
                                        input int vz, input bit unit);
    rot_req_t req;
    req.quat[0] = qx;
    req.quat[1] = qy;
    req.quat[2] = qz;
    req.quat[3] = qw;
    req.vec[0] = vx;
    req.vec[1] = vy;
    req.vec[2] = vz;
    req.unit = unit;
    return req;
  endfunction

  function automatic int rand_span(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Driver: offers queued requests with random gaps, records each accepted transaction
  int send_gap;
  always @(posedge clk) begin
    rot_req_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        req.quat[0] = in_ch.quat_x;
        req.quat[1] = in_ch.quat_y;
        req.quat[2] = in_ch.quat_z;
        req.quat[3] = in_ch.quat_w;
        req.vec[0] = in_ch.vec_x;
        req.vec[1] = in_ch.vec_y;
        req.vec[2] = in_ch.vec_z;
        req.unit = in_ch.already_unit;
        expected_rots.push_back(rotate(req));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req = pending_reqs.pop_front();
          in_ch.quat_x <= req.quat[0];
          in_ch.quat_y <= req.quat[1];
          in_ch.quat_z <= req.quat[2];
          in_ch.quat_w <= req.quat[3];
          in_ch.vec_x <= req.vec[0];
          in_ch.vec_y <= req.vec[1];
          in_ch.vec_z <= req.vec[2];
          in_ch.already_unit <= req.unit;
          in_ch.valid <= 1'b1;
          send_gap = send_burst ? 0 : $urandom_range(0, 6);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls plus one long hold-off, checks each result transaction
  int take_stall;
  always @(posedge clk) begin
    rot_vec_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rots.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_rots.pop_front();
          if (out_ch.rot_x !== want.v[0])
            report($sformatf("rot_x %h, want %h", out_ch.rot_x, want.v[0]));
          if (out_ch.rot_y !== want.v[1])
            report($sformatf("rot_y %h, want %h", out_ch.rot_y, want.v[1]));
          if (out_ch.rot_z !== want.v[2])
            report($sformatf("rot_z %h, want %h", out_ch.rot_z, want.v[2]));
        end
        results_seen++;
        take_stall = take_burst ? 0 : $urandom_range(0, 6);
        if (results_seen == HOLD_AT) take_stall = HOLD_LEN;
      end else if (take_stall > 0) begin
        take_stall--;
      end
      out_ch.ready <= (take_stall == 0);
    end
  end

  // Stimulus and end of run
  initial begin
    int one;
    int hw;
    int pick;
    rst_n = 1'b0;
    errors = 0;
    results_seen = 0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.quat_w = '0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    in_ch.already_unit = 1'b0;
    out_ch.ready = 1'b0;
    one = 1 << FB;
    hw = 46341;  // about sqrt(0.5) in Q16.16

    // directed: zero quaternion, identity, quarter turns, extremes, unscaled non-unit
    pending_reqs.push_back(make_req(0, 0, 0, 0, one, -one, 3 * one, 1'b0));
    pending_reqs.push_back(make_req(0, 0, 0, 0, one, -one, 3 * one, 1'b1));
    pending_reqs.push_back(make_req(0, 0, 0, one, 5 * one, -2 * one, one, 1'b1));
    pending_reqs.push_back(make_req(0, 0, 0, 7, 5 * one, -2 * one, one, 1'b0));
    pending_reqs.push_back(make_req(0, 0, hw, hw, one, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(hw, 0, 0, -hw, 0, one, 0, 1'b1));
    pending_reqs.push_back(make_req(0, 3, 0, 3, 0, 0, one, 1'b0));
    pending_reqs.push_back(make_req(one, 0, 0, 0, one, one, one, 1'b1));
    pending_reqs.push_back(make_req(1, 0, 0, 0, 1, 2, 3, 1'b0));
    pending_reqs.push_back(make_req(-1, 0, 0, 0, 1, 2, 3, 1'b0));
    pending_reqs.push_back(make_req(int'(32'h80000000), int'(32'h80000000),
        int'(32'h80000000), int'(32'h80000000), int'(32'h80000000),
        int'(32'h80000000), int'(32'h80000000), 1'b0));
    pending_reqs.push_back(make_req(int'(32'h80000000), int'(32'h80000000),
        int'(32'h80000000), int'(32'h80000000), int'(32'h80000000),
        int'(32'h80000000), int'(32'h80000000), 1'b1));
    pending_reqs.push_back(make_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0));
    pending_reqs.push_back(make_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
    pending_reqs.push_back(make_req(32'h7fffffff, int'(32'h80000000), 0, 32'h7fffffff,
        int'(32'h80000000), 32'h7fffffff, -1, 1'b0));
    pending_reqs.push_back(make_req(2 * one, 0, 0, 0, 30000 * one, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(0, 2 * one, one, one, -30000 * one, 9 * one,
        20000 * one, 1'b1));
    pending_reqs.push_back(make_req(-one, -one, -one, -one, -7 * one, 3, -1, 1'b0));
    pending_reqs.push_back(make_req(0, 0, 0, -one, 0, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(12345, -54321, 999, -77, 32'h7fffffff,
        int'(32'h80000000), 0, 1'b0));

    // random: mostly plausible rotations, some full-range noise
    for (int n = 0; n < 400; n++) begin
      rot_req_t req;
      pick = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
        if (pick < 5) req.quat[i] = rand_span(1 << 20);
        else if (pick < 8) req.quat[i] = rand_span(one);
        else req.quat[i] = $urandom;
      end
      for (int i = 0; i < 3; i++)
        req.vec[i] = pick < 8 ? rand_span(1 << 26) : $urandom;
      req.unit = pick < 5 ? 1'b0 : pick < 8 ? 1'b1 : 1'($urandom);
      pending_reqs.push_back(req);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // stretches with and without idling on either side
    while (pending_reqs.size() != 0) begin
      repeat ($urandom_range(50, 200)) @(posedge clk);
      send_burst <= ~send_burst;
      take_burst <= 1'($urandom);
    end
    take_burst <= 1'b0;
    while (in_ch.valid || expected_rots.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/qrv_pkg.sv
rtl/qrv_if.sv
rtl/qrv_mul.sv
rtl/quaternion_rotate_vector_top.sv
rtl/qrv_chk.sv
tb/sv/testbench.sv
